@@ rtl/chxy_pkg.sv @@
// chxy_pkg: constants and the step angle table for the compass heading unit
// no dependencies; imported by compass_heading_from_xy_unit, its checker and its testbench
`timescale 1ns / 1ps

package chxy_pkg;

  localparam int GUARD_BITS = 24;
  localparam int TABLE_LEN  = 24;
  localparam int STEP_WIDTH = 22;
  localparam int ZW         = 27;
  localparam int OUT_SHIFT  = 9;
  localparam int HEAD_WIDTH = 16;

  localparam logic signed [ZW-1:0]       DEG_180    = 27'sd11796480;
  localparam logic signed [ZW-1:0]       DEG_360    = 27'sd23592960;
  localparam logic [ZW-1:0]              ROUND_HALF = 27'd256;
  localparam logic [HEAD_WIDTH-1:0]      FULL_TURN  = 16'd46080;

  // atan(2^-i) in degrees, scaled by 2^16
  localparam logic [STEP_WIDTH-1:0] STEP_ANGLE [TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

endpackage

@@ rtl/compass_heading_from_xy_unit.sv @@
// Throughput: one request per cycle unless out_stall holds the output; one
// CORDIC micro-rotation per stage, plus a fold stage in front and a wrap and
// round stage at the output.
// A stall holds every stage; empty stages in front of a stall still fill.
// Reset (rst, synchronous) clears the stage valid bits only.
// compass_heading_from_xy_unit: pipelined CORDIC atan2 compass heading
// depends on chxy_pkg
`timescale 1ns / 1ps

module compass_heading_from_xy_unit
  import chxy_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 16,
  parameter int SAMPLE_WIDTH     = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] field_x,
  input  logic signed [SAMPLE_WIDTH-1:0] field_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [HEAD_WIDTH-1:0]          heading
);

  localparam int NSTEP = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;
  localparam int W     = SAMPLE_WIDTH + GUARD_BITS + 3;

  logic signed [W-1:0]  cx   [0:NSTEP];
  logic signed [W-1:0]  cy   [0:NSTEP];
  logic signed [ZW-1:0] z    [0:NSTEP];
  logic                 zero [0:NSTEP];
  logic                 vld  [0:NSTEP];
  logic                 ld   [0:NSTEP+1];

  // load enables, bubbles collapse ahead of a stall
  assign ld[NSTEP+1] = !out_valid || !out_stall;
  generate
    for (genvar s = 0; s <= NSTEP; s++) begin : g_ld
      assign ld[s] = !vld[s] || ld[s+1];
    end
  endgenerate
  assign in_stall = !ld[0];

  // fold stage: negate y, scale up, turn by 180 degrees when x is negative
  logic signed [W-1:0]  xg, yg, cx_next, cy_next;
  logic signed [ZW-1:0] z_next;

  always_comb begin
    xg = W'(field_x) <<< GUARD_BITS;
    yg = (-W'(field_y)) <<< GUARD_BITS;
    if (field_x[SAMPLE_WIDTH-1]) begin
      cx_next = -xg;
      cy_next = -yg;
      z_next  = DEG_180;
    end else begin
      cx_next = xg;
      cy_next = yg;
      z_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ld[0]) begin
      vld[0] <= in_valid;
    end
    if (ld[0]) begin
      cx[0]   <= cx_next;
      cy[0]   <= cy_next;
      z[0]    <= z_next;
      zero[0] <= (field_x == '0) && (field_y == '0);
    end
  end

  // micro-rotation stages
  generate
    for (genvar k = 0; k < NSTEP; k++) begin : g_rot
      logic signed [ZW-1:0] step;
      assign step = $signed(ZW'(STEP_ANGLE[k]));

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (ld[k+1]) begin
          vld[k+1] <= vld[k];
        end
        if (ld[k+1]) begin
          zero[k+1] <= zero[k];
          if (!cy[k][W-1]) begin
            cx[k+1] <= cx[k] + (cy[k] >>> k);
            cy[k+1] <= cy[k] - (cx[k] >>> k);
            z[k+1]  <= z[k] + step;
          end else begin
            cx[k+1] <= cx[k] - (cy[k] >>> k);
            cy[k+1] <= cy[k] + (cx[k] >>> k);
            z[k+1]  <= z[k] - step;
          end
        end
      end
    end
  endgenerate

  // wrap into one turn, round to 1/128 degree
  logic signed [ZW-1:0]    zw;
  logic [ZW-1:0]           zr;
  logic [HEAD_WIDTH-1:0]   hraw, heading_next;

  always_comb begin
    zw = z[NSTEP][ZW-1] ? (z[NSTEP] + DEG_360) : z[NSTEP];
    zr = $unsigned(zw) + ROUND_HALF;
    hraw = zr[OUT_SHIFT+HEAD_WIDTH-1:OUT_SHIFT];
    if (zero[NSTEP] || hraw == FULL_TURN) begin
      heading_next = '0;
    end else begin
      heading_next = hraw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld[NSTEP+1]) begin
      out_valid <= vld[NSTEP];
    end
    if (ld[NSTEP+1]) begin
      heading <= heading_next;
    end
  end

`ifndef SYNTH
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading < FULL_TURN)
    else $error("heading out of range");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without output back-pressure");

  a_refill: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && vld[NSTEP] |=> out_valid)
    else $error("output stage failed to refill");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !vld[0])
    else $error("valid bits not cleared by reset");
`endif

endmodule

@@ tb/sv/compass_heading_checker.sv @@
// compass_heading_checker: watches both channels of the compass heading unit,
// predicts each heading from its request and compares in order
// depends on chxy_pkg
`timescale 1ns / 1ps

module compass_heading_checker
  import chxy_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 16,
  parameter int SAMPLE_WIDTH     = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] field_x,
  input  logic signed [SAMPLE_WIDTH-1:0] field_y,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [HEAD_WIDTH-1:0]          heading,
  output int                             failures,
  output int                             pending
);

  localparam int    ATAN_ENTRIES  = 24;
  localparam int    ANGLE_FRAC    = 16;
  localparam int    LSB_SHIFT     = ANGLE_FRAC - 7;
  localparam longint HALF_TURN_Q  = longint'(180) <<< ANGLE_FRAC;
  localparam longint FULL_TURN_Q  = longint'(360) <<< ANGLE_FRAC;
  localparam longint HEADING_WRAP = 46080;

  // atan(2^-k) in degrees, scaled by 2^16
  localparam longint ATAN_DEG_Q16 [ATAN_ENTRIES] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic [HEAD_WIDTH-1:0]          deg;
  } heading_req_t;

  heading_req_t heading_q[$];

  function automatic logic [HEAD_WIDTH-1:0] compass_heading(
    input logic signed [SAMPLE_WIDTH-1:0] sx,
    input logic signed [SAMPLE_WIDTH-1:0] sy
  );
    longint vx, vy, ang, step_x, step_y, rounded;
    int     n_steps;
    vx = sx;
    vy = -longint'(sy);
    ang = 0;
    if (vx == 0 && vy == 0) begin
      return '0;
    end
    vx = vx <<< 24;
    vy = vy <<< 24;
    // left half plane: turn by 180 degrees first
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      ang = HALF_TURN_Q;
    end
    n_steps = (ANGLE_ITERATIONS < ATAN_ENTRIES) ? ANGLE_ITERATIONS : ATAN_ENTRIES;
    for (int k = 0; k < n_steps; k++) begin
      step_x = vy >>> k;
      step_y = vx >>> k;
      if (vy >= 0) begin
        vx  = vx + step_x;
        vy  = vy - step_y;
        ang = ang + ATAN_DEG_Q16[k];
      end else begin
        vx  = vx - step_x;
        vy  = vy + step_y;
        ang = ang - ATAN_DEG_Q16[k];
      end
    end
    while (ang < 0) ang = ang + FULL_TURN_Q;
    while (ang >= FULL_TURN_Q) ang = ang - FULL_TURN_Q;
    rounded = (ang + (longint'(1) <<< (LSB_SHIFT - 1))) >>> LSB_SHIFT;
    if (rounded >= HEADING_WRAP) begin
      rounded = 0;
    end
    return rounded[HEAD_WIDTH-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    failures++;
  endtask

  always @(posedge clk) begin
    heading_req_t head;
    heading_req_t req;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (heading_q.size() == 0) begin
          report_mismatch($sformatf("heading %0d with no request waiting", heading));
        end else begin
          head = heading_q.pop_front();
          if (heading !== head.deg) begin
            report_mismatch($sformatf("heading for x=%0d y=%0d: got %0d, want %0d",
                                      head.x, head.y, heading, head.deg));
          end
        end
      end
      if (in_valid && !in_stall) begin
        req.x   = field_x;
        req.y   = field_y;
        req.deg = compass_heading(field_x, field_y);
        heading_q.push_back(req);
      end
    end
    pending <= heading_q.size();
  end

endmodule

@@ tb/sv/tb_compass_heading_from_xy_unit.sv @@
// tb_compass_heading_from_xy_unit: drives sample pairs into the compass heading
// unit with random idling on both sides and gives the verdict
// depends on chxy_pkg, compass_heading_from_xy_unit, compass_heading_checker
`timescale 1ns / 1ps

module tb_compass_heading_from_xy_unit;
  import chxy_pkg::*;

  localparam int SW         = 16;
  localparam int ITERS      = 16;
  localparam int STUCK_MAX  = 1000;
  localparam int HOLD_LEN   = 60;
  localparam int TAIL_WAIT  = 40;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SW-1:0] field_x;
  logic signed [SW-1:0] field_y;
  logic                 out_valid;
  logic                 out_stall;
  logic [HEAD_WIDTH-1:0] heading;
  logic                 idling;
  int                   hold_reqs;
  int                   failures;
  int                   pending;
  int                   stuck_cycles;

  compass_heading_from_xy_unit #(
    .ANGLE_ITERATIONS(ITERS),
    .SAMPLE_WIDTH    (SW)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .field_x  (field_x),
    .field_y  (field_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .heading  (heading)
  );

  compass_heading_checker #(
    .ANGLE_ITERATIONS(ITERS),
    .SAMPLE_WIDTH    (SW)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .field_x  (field_x),
    .field_y  (field_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .heading  (heading),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on cycles with no request or heading moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_MAX) begin
        $display("tb_compass_heading_from_xy_unit NOT OK");
        $finish;
      end
    end
  end

  // receiver: short random holds, plus one long hold on request
  initial begin
    int hold_done;
    hold_done = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  task automatic send_pair(input logic signed [SW-1:0] x, input logic signed [SW-1:0] y);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    field_x  <= x;
    field_y  <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic signed [SW-1:0] pick_sample(input int mode);
    logic signed [SW-1:0] v;
    case (mode)
      0:       v = SW'(int'($urandom_range(0, 8)) - 4);
      1:       v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2:       v = SW'(int'($urandom_range(0, 512)) - 256);
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_random(input int count);
    logic signed [SW-1:0] x, y;
    int mx, my;
    for (int n = 0; n < count; n++) begin
      mx = $urandom_range(0, 9);
      my = $urandom_range(0, 9);
      // mostly full range, some tiny, near-axis and extreme values
      x = pick_sample(mx > 3 ? 3 : mx);
      y = pick_sample(my > 3 ? 3 : my);
      send_pair(x, y);
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    field_x   = '0;
    field_y   = '0;
    idling    = 1'b1;
    hold_reqs = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero vector, axes, extremes, both sides of the wrap and of 180
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sh7fff, 16'sd0);
    send_pair(16'sh8000, 16'sd0);
    send_pair(16'sd0, 16'sh7fff);
    send_pair(16'sd0, 16'sh8000);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh7fff, 16'sh7fff);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sd1, 16'sd0);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd0, 16'sd1);
    send_pair(16'sd0, -16'sd1);
    send_pair(16'sd1, 16'sd1);
    send_pair(-16'sd1, -16'sd1);
    send_pair(-16'sd1, 16'sd1);
    send_pair(16'sd1, -16'sd1);
    send_pair(16'sh7fff, 16'sd1);
    send_pair(16'sh7fff, -16'sd1);
    send_pair(16'sh8000, 16'sd1);
    send_pair(16'sh8000, -16'sd1);
    send_pair(16'sd100, -16'sd100);
    send_pair(-16'sd12345, 16'sd321);
    drain_all();

    send_random(600);

    // long receiver hold while requests keep coming
    hold_reqs <= hold_reqs + 1;
    send_random(80);
    drain_all();

    send_random(450);

    idling <= 1'b0;
    send_random(200);
    drain_all();

    in_valid <= 1'b0;
    repeat (TAIL_WAIT) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb_compass_heading_from_xy_unit OK");
    end else begin
      $display("tb_compass_heading_from_xy_unit NOT OK");
    end
    $finish;
  end

endmodule

@@ compass_heading_from_xy_unit.f @@
rtl/chxy_pkg.sv
rtl/compass_heading_from_xy_unit.sv
tb/sv/compass_heading_checker.sv
tb/sv/tb_compass_heading_from_xy_unit.sv
